>>> rtl/core/vbs_pkg.sv
// Shared types, constants and hash terms for the band smear block.
package vbs_pkg;

    localparam int MAX_BAND_COUNT = 5;
    localparam int MIN_BAND_ROWS  = 2;
    localparam int MAX_BAND_ROWS  = 24;
    localparam int MAX_SLAB_ROWS  = 16;
    localparam int MAX_ROW_PIXELS = 2048;

    localparam int BAND_IDX_W = (MAX_BAND_COUNT > 1) ? $clog2(MAX_BAND_COUNT) : 1;
    localparam int BAND_CNT_W = $clog2(MAX_BAND_COUNT + 1);
    localparam int BAND_SPAN  = MAX_BAND_ROWS - MIN_BAND_ROWS + 1;
    localparam int BH_W       = $clog2(MAX_BAND_ROWS + 1);

    localparam logic [12:0] ROW_LIMIT = 13'd8191;

    localparam logic [31:0] HASH_MUL_Y = 32'd2654435761;
    localparam logic [31:0] HASH_MUL   = 32'h045d9f3b;
    localparam logic [31:0] FRAME_SALT = 32'hCAFEBABE;
    localparam logic [31:0] ROW_SALT   = 32'hFEEDF00D;
    localparam logic [31:0] LCG_MUL    = 32'd1664525;
    localparam logic [31:0] LCG_ADD    = 32'd1013904223;

    // y * HASH_MUL_Y terms for the fixed second hash arguments
    localparam logic [31:0] FRAME_SALT_MIX = 32'(64'(FRAME_SALT) * 64'(HASH_MUL_Y));
    localparam logic [31:0] ROW_SALT_MIX   = 32'(64'(ROW_SALT) * 64'(HASH_MUL_Y));
    localparam logic [31:0] HEIGHT_MIX     = HASH_MUL_Y;
    localparam logic [31:0] TOP_MIX        = 32'(64'(HASH_MUL_Y) * 64'd2);

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH     = 3'd0,
        REG_FRAME_HEIGHT    = 3'd1,
        REG_BAND_COUNT      = 3'd2,
        REG_SLAB_ROWS       = 3'd3,
        REG_SMEAR_THRESHOLD = 3'd4,
        REG_FLUTTER_PERIOD  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [11:0] frame_width;
        logic [12:0] frame_height;
        logic [2:0]  band_count;
        logic [4:0]  slab_rows;
        logic [31:0] smear_threshold;
        logic [13:0] flutter_period;
    } cfg_t;

    typedef struct packed {
        logic [23:0] pix;
        logic        last;
        logic        row_start;
        logic        in_band;
        logic [31:0] seed;
    } q_word_t;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [13:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
        logic [13:0] rem;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOW,
        S_SEED_A,
        S_SEED_B,
        S_HT_A,
        S_HT_B,
        S_HT_DIV,
        S_TOP_A,
        S_TOP_B,
        S_TOP_DIV,
        S_ROW,
        S_ROW_DIV,
        S_ROW_A,
        S_ROW_B,
        S_PUSH
    } front_state_t;

endpackage

>>> rtl/core/vbs_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module vbs_div (
    input  logic              clk,
    input  logic              rst_n,
    input  vbs_pkg::div_req_t req,
    output vbs_pkg::div_rsp_t rsp
);
    import vbs_pkg::*;

    logic [31:0] num_reg, num_next;
    logic [13:0] den_reg, den_next;
    logic [13:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [14:0] trial;
    logic        ge;

    always_comb
    begin
        trial     = {rem_reg, num_reg[31]};
        ge        = trial >= {1'b0, den_reg};
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 14'(trial - {1'b0, den_reg}) : trial[13:0];
            num_next = {num_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;
    assign rsp.rem  = rem_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");
endmodule

>>> rtl/core/vbs_queue.sv
// Short word queue between the classifying front and the pixel back end.
module vbs_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  vbs_pkg::q_word_t push_word,
    output logic             full,
    input  logic             pop,
    output vbs_pkg::q_word_t pop_word,
    output logic             empty
);
    import vbs_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    q_word_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;

    assign full     = cnt_reg == (PTR_W+1)'(DEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PTR_W+1)'(DEPTH))
        else $error("queue count out of range");
endmodule

>>> rtl/core/vbs_front.sv
// Front end: raster counters, frame band setup and row classification.
module vbs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  vbs_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              frame_first,
    input  logic [7:0]        red_in,
    input  logic [7:0]        green_in,
    input  logic [7:0]        blue_in,
    output logic              q_push,
    output vbs_pkg::q_word_t  q_word,
    input  logic              q_full,
    output vbs_pkg::div_req_t div_req,
    input  vbs_pkg::div_rsp_t div_rsp
);
    import vbs_pkg::*;

    front_state_t state_reg, state_next;

    logic [11:0]           column_reg, column_next;
    logic [12:0]           row_reg, row_next;
    logic [31:0]           frame_count_reg, frame_count_next;
    logic [BAND_CNT_W-1:0] bands_built_reg, bands_built_next;
    logic [BAND_IDX_W-1:0] band_idx_reg;
    logic [12:0]           top_reg  [MAX_BAND_COUNT];
    logic [12:0]           bot_reg  [MAX_BAND_COUNT];
    logic [31:0]           seed_reg [MAX_BAND_COUNT];

    logic [31:0]    acc_reg, s_reg, t_reg, hit_seed_reg, word_seed_reg;
    logic [BH_W-1:0] bh_reg;
    logic [12:0]    row_cur_reg, base_reg;
    logic [23:0]    pix_reg;
    logic           last_reg, word_inb_reg;

    logic        accept;
    logic [11:0] colz, width1;
    logic [12:0] rowz, height1;
    logic        last;
    logic [2:0]  n_clamp;
    logic [4:0]  slab;
    logic [13:0] period1;
    logic        wide;
    logic [31:0] hash_x, hash_c, hash_p, t_next, hash_m, hash_calc;
    logic        hit;
    logic [BAND_IDX_W-1:0] hit_idx;
    logic [12:0] y0, rem13;
    logic [13:0] y_sum;
    logic        band_last;

    assign width1  = (cfg.frame_width == '0) ? 12'd1 : cfg.frame_width;
    assign height1 = (cfg.frame_height == '0) ? 13'd1 : cfg.frame_height;
    assign period1 = (cfg.flutter_period == '0) ? 14'd1 : cfg.flutter_period;
    assign n_clamp = (cfg.band_count > 3'(MAX_BAND_COUNT)) ? 3'(MAX_BAND_COUNT)
                                                           : cfg.band_count;
    always_comb
    begin
        if (cfg.slab_rows == '0)
            slab = 5'd1;
        else if (cfg.slab_rows > 5'(MAX_SLAB_ROWS))
            slab = 5'(MAX_SLAB_ROWS);
        else
            slab = cfg.slab_rows;
    end
    assign wide = {1'b0, width1} > 13'(MAX_ROW_PIXELS);

    assign in_stall = !((state_reg == S_IDLE) && !q_full);
    assign accept   = in_valid && !in_stall;

    assign colz = frame_first ? 12'd0 : column_reg;
    assign rowz = frame_first ? 13'd0 : row_reg;
    assign last = ({1'b0, colz} + 13'd1) >= {1'b0, width1};

    // first band (lowest index) holding the current row wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int b = MAX_BAND_COUNT - 1; b >= 0; b--)
        begin
            if ((BAND_CNT_W'(b) < bands_built_reg) && (row_cur_reg >= top_reg[b])
                && (row_cur_reg <= bot_reg[b]))
            begin
                hit     = 1'b1;
                hit_idx = BAND_IDX_W'(b);
            end
        end
    end

    // integer hash: xor/shift into t_reg, then multiply/xor
    always_comb
    begin
        unique case (state_reg)
            S_SEED_A:
            begin
                hash_x = acc_reg;
                hash_c = FRAME_SALT_MIX;
            end
            S_HT_A:
            begin
                hash_x = s_reg;
                hash_c = HEIGHT_MIX;
            end
            S_TOP_A:
            begin
                hash_x = s_reg;
                hash_c = TOP_MIX;
            end
            default:
            begin
                hash_x = hit_seed_reg ^ (32'(base_reg) << 3);
                hash_c = ROW_SALT_MIX;
            end
        endcase
        hash_p    = hash_x ^ hash_c;
        t_next    = hash_p ^ (hash_p >> 16);
        hash_m    = 32'(t_reg * HASH_MUL);
        hash_calc = hash_m ^ (hash_m >> 16);
    end

    assign rem13     = div_rsp.rem[12:0];
    assign y_sum     = {1'b0, rem13} + 14'(bh_reg);
    assign band_last = (BAND_CNT_W'(band_idx_reg) + 1'b1) == bands_built_reg;
    always_comb
    begin
        if (y_sum >= {1'b0, height1})
            y0 = (height1 > 13'(bh_reg)) ? 13'(height1 - 13'd1 - 13'(bh_reg)) : 13'd0;
        else
            y0 = rem13;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (frame_first || colz == '0))
                    state_next = (frame_first && !wide) ? S_SLOW : S_ROW;
            end
            S_SLOW:
            begin
                if (div_rsp.done)
                    state_next = (bands_built_reg == '0) ? S_ROW : S_SEED_A;
            end
            S_SEED_A:  state_next = S_SEED_B;
            S_SEED_B:  state_next = S_HT_A;
            S_HT_A:    state_next = S_HT_B;
            S_HT_B:    state_next = S_HT_DIV;
            S_HT_DIV:  if (div_rsp.done) state_next = S_TOP_A;
            S_TOP_A:   state_next = S_TOP_B;
            S_TOP_B:   state_next = S_TOP_DIV;
            S_TOP_DIV:
            begin
                if (div_rsp.done)
                    state_next = band_last ? S_ROW : S_SEED_A;
            end
            S_ROW:     state_next = hit ? S_ROW_DIV : S_PUSH;
            S_ROW_DIV: if (div_rsp.done) state_next = S_ROW_A;
            S_ROW_A:   state_next = S_ROW_B;
            S_ROW_B:   state_next = S_PUSH;
            S_PUSH:    if (!q_full) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs and counters
    always_comb
    begin
        column_next      = column_reg;
        row_next         = row_reg;
        frame_count_next = frame_count_reg;
        bands_built_next = bands_built_reg;
        div_req.start    = 1'b0;
        div_req.num      = 32'(row_cur_reg);
        div_req.den      = 14'(slab);
        q_push           = 1'b0;
        q_word.pix       = pix_reg;
        q_word.last      = last_reg;
        q_word.row_start = 1'b1;
        q_word.in_band   = word_inb_reg;
        q_word.seed      = word_seed_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    column_next = last ? 12'd0 : colz + 12'd1;
                    row_next    = (last && rowz < ROW_LIMIT) ? rowz + 13'd1 : rowz;
                    if (frame_first)
                    begin
                        bands_built_next = wide ? '0 : BAND_CNT_W'(n_clamp);
                        if (!wide)
                        begin
                            frame_count_next = frame_count_reg + 32'd1;
                            div_req.start    = 1'b1;
                            div_req.num      = frame_count_reg + 32'd1;
                            div_req.den      = period1;
                        end
                    end
                    else if (colz != '0)
                    begin
                        q_push           = 1'b1;
                        q_word.pix       = {blue_in, green_in, red_in};
                        q_word.last      = last;
                        q_word.row_start = 1'b0;
                        q_word.in_band   = 1'b0;
                    end
                end
            end
            S_HT_B:
            begin
                div_req.start = 1'b1;
                div_req.num   = hash_calc;
                div_req.den   = 14'(BAND_SPAN);
            end
            S_TOP_B:
            begin
                div_req.start = 1'b1;
                div_req.num   = hash_calc;
                div_req.den   = 14'(height1);
            end
            S_ROW:
            begin
                div_req.start = hit;
            end
            S_PUSH:
            begin
                q_push = !q_full;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            column_reg      <= '0;
            row_reg         <= '0;
            frame_count_reg <= '1;
            bands_built_reg <= '0;
            band_idx_reg    <= '0;
            for (int b = 0; b < MAX_BAND_COUNT; b++)
            begin
                top_reg[b]  <= '0;
                bot_reg[b]  <= '0;
                seed_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            column_reg      <= column_next;
            row_reg         <= row_next;
            frame_count_reg <= frame_count_next;
            bands_built_reg <= bands_built_next;
            if (state_reg == S_SLOW && div_rsp.done)
                band_idx_reg <= '0;
            if (state_reg == S_TOP_DIV && div_rsp.done)
            begin
                top_reg[band_idx_reg]  <= y0;
                bot_reg[band_idx_reg]  <= 13'(y0 + 13'(bh_reg));
                seed_reg[band_idx_reg] <= s_reg;
                band_idx_reg           <= band_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        if (accept)
        begin
            pix_reg     <= {blue_in, green_in, red_in};
            last_reg    <= last;
            row_cur_reg <= rowz;
        end
        if (state_reg == S_SLOW && div_rsp.done)
            acc_reg <= div_rsp.quot;
        if (state_reg == S_TOP_DIV && div_rsp.done)
            acc_reg <= acc_reg + HASH_MUL_Y;
        if (state_reg == S_SEED_B)
            s_reg <= hash_calc;
        if (state_reg == S_HT_DIV && div_rsp.done)
            bh_reg <= BH_W'(div_rsp.rem) + BH_W'(MIN_BAND_ROWS);
        if (state_reg == S_ROW)
        begin
            hit_seed_reg <= seed_reg[hit_idx];
            word_inb_reg <= hit;
        end
        if (state_reg == S_ROW_DIV && div_rsp.done)
            base_reg <= row_cur_reg - rem13;
        if (state_reg == S_ROW_B)
            word_seed_reg <= hash_calc;
    end

    a_band_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEED_A) |-> (BAND_CNT_W'(band_idx_reg) < bands_built_reg))
        else $error("band index past built count");
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");
    a_wait_has_div: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SLOW || state_reg == S_HT_DIV || state_reg == S_TOP_DIV
          || state_reg == S_ROW_DIV) && !div_rsp.done) |-> div_rsp.busy)
        else $error("waiting on an idle divider");
    a_bands_built_max: assert property (@(posedge clk) disable iff (!rst_n)
        bands_built_reg <= BAND_CNT_W'(MAX_BAND_COUNT))
        else $error("too many bands built");
endmodule

>>> rtl/core/vbs_back.sv
// Back end: per-pixel LCG, hold decision and output register.
module vbs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      smear_threshold,
    input  vbs_pkg::q_word_t q_word,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       red_out,
    output logic [7:0]       green_out,
    output logic [7:0]       blue_out,
    output logic             row_end
);
    import vbs_pkg::*;

    logic [31:0] rs_reg, rs_next;
    logic        inb_reg, inb_next;
    logic [23:0] held_reg, held_next;
    logic        out_valid_reg, out_valid_next;
    logic [23:0] res_reg, res_next;
    logic        last_reg;
    logic [31:0] rs_cur, lcg;
    logic [23:0] held_cur;
    logic        reseed;

    assign q_pop  = !q_empty && (!out_valid_reg || !out_stall);
    assign reseed = q_word.row_start && q_word.in_band;

    always_comb
    begin
        rs_cur    = reseed ? q_word.seed : rs_reg;
        held_cur  = reseed ? q_word.pix : held_reg;
        inb_next  = q_word.row_start ? q_word.in_band : inb_reg;
        lcg       = 32'(rs_cur * LCG_MUL) + LCG_ADD;
        rs_next   = rs_reg;
        held_next = held_reg;
        res_next  = q_word.pix;
        if (inb_next)
        begin
            rs_next   = lcg;
            held_next = held_cur;
            if (lcg <= smear_threshold)
                res_next = held_cur;
            else
                held_next = q_word.pix;
        end
        out_valid_next = q_pop ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg        <= '0;
            inb_reg       <= 1'b0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                rs_reg   <= rs_next;
                inb_reg  <= inb_next;
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg  <= res_next;
            last_reg <= q_word.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = res_reg[7:0];
    assign green_out = res_reg[15:8];
    assign blue_out  = res_reg[23:16];
    assign row_end   = last_reg;

    a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!out_valid_reg || !out_stall))
        else $error("pop would overwrite a pending word");
    a_pass_outside_band: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !inb_next) |=> (res_reg == $past(q_word.pix)))
        else $error("pixel outside band altered");
    a_reseed_sets_band: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && reseed) |=> inb_reg)
        else $error("band flag not set on reseed");
endmodule

>>> rtl/core/video_band_smear.sv
// Band smear top level: register file, front end, queue, divider and back end.
// Throughput: one pixel per cycle inside a row while the output does not stall;
// a frame's first pixel (band setup), and a row's first pixel when its row lies
// in a band (slab divide plus hash), hold the input while the shared 32-step
// serial divider runs.
// Reset: asynchronous; no bands exist and all pixels pass until a frame starts.
module video_band_smear (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        frame_first,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic        row_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [vbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    import vbs_pkg::*;

    cfg_t     cfg_reg;
    q_word_t  push_word, pop_word;
    logic     q_push, q_pop, q_full, q_empty;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width     <= 12'd640;
            cfg_reg.frame_height    <= 13'd480;
            cfg_reg.band_count      <= 3'd0;
            cfg_reg.slab_rows       <= 5'd1;
            cfg_reg.smear_threshold <= 32'd0;
            cfg_reg.flutter_period  <= 14'd10000;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:     cfg_reg.frame_width     <= cfg_data[11:0];
                REG_FRAME_HEIGHT:    cfg_reg.frame_height    <= cfg_data[12:0];
                REG_BAND_COUNT:      cfg_reg.band_count      <= cfg_data[2:0];
                REG_SLAB_ROWS:       cfg_reg.slab_rows       <= cfg_data[4:0];
                REG_SMEAR_THRESHOLD: cfg_reg.smear_threshold <= cfg_data;
                REG_FLUTTER_PERIOD:  cfg_reg.flutter_period  <= cfg_data[13:0];
                default:
                begin
                end
            endcase
        end
    end

    vbs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .frame_first (frame_first),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .q_push      (q_push),
        .q_word      (push_word),
        .q_full      (q_full),
        .div_req     (div_req),
        .div_rsp     (div_rsp)
    );

    vbs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    vbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .pop_word  (pop_word),
        .empty     (q_empty)
    );

    vbs_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .smear_threshold (cfg_reg.smear_threshold),
        .q_word          (pop_word),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .red_out         (red_out),
        .green_out       (green_out),
        .blue_out        (blue_out),
        .row_end         (row_end)
    );
endmodule

>>> tb/video_band_smear_tb.sv
// Testbench for the band smear block: pixel streams checked against a predictor.
`timescale 1ns / 1ps

module video_band_smear_tb;
    import vbs_pkg::*;

    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
    } pixel_out_t;

    // Predicts the smeared pixel stream and checks the block's output against it.
    class smear_scoreboard;
        logic [11:0] width_reg;
        logic [12:0] height_reg;
        logic [2:0]  bands_reg;
        logic [4:0]  slab_reg;
        logic [31:0] thresh_reg;
        logic [13:0] period_reg;

        logic [31:0] frame_cnt;
        logic [31:0] top_row [MAX_BAND_COUNT];
        logic [31:0] bot_row [MAX_BAND_COUNT];
        logic [31:0] seed [MAX_BAND_COUNT];
        logic [31:0] col;
        logic [31:0] row;
        logic [31:0] lcg;
        logic [23:0] held;
        bit          in_band;
        int          bands_live;
        pixel_out_t  pending[$];
        int          errors;

        function new();
            width_reg = 640;
            height_reg = 480;
            bands_reg = 0;
            slab_reg = 1;
            thresh_reg = 0;
            period_reg = 10000;
            frame_cnt = '1;
            foreach (top_row[i])
            begin
                top_row[i] = 0;
                bot_row[i] = 0;
                seed[i] = 0;
            end
            col = 0;
            row = 0;
            lcg = 0;
            held = 0;
            in_band = 0;
            bands_live = 0;
            errors = 0;
        endfunction

        function logic [31:0] mix(logic [31:0] x, logic [31:0] y);
            logic [31:0] h;
            h = x ^ (y * 32'd2654435761);
            h = h ^ (h >> 16);
            h = h * 32'h045d9f3b;
            h = h ^ (h >> 16);
            return h;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [31:0] value);
            case (idx)
                REG_FRAME_WIDTH:     width_reg = value[11:0];
                REG_FRAME_HEIGHT:    height_reg = value[12:0];
                REG_BAND_COUNT:      bands_reg = value[2:0];
                REG_SLAB_ROWS:       slab_reg = value[4:0];
                REG_SMEAR_THRESHOLD: thresh_reg = value;
                REG_FLUTTER_PERIOD:  period_reg = value[13:0];
                default: ;
            endcase
        endfunction

        function void begin_frame();
            logic [31:0] h, w, p, slow, s;
            longint bh, y0;
            int n;
            h = (height_reg == 0) ? 1 : height_reg;
            w = (width_reg == 0) ? 1 : width_reg;
            p = (period_reg == 0) ? 1 : period_reg;
            n = (bands_reg > MAX_BAND_COUNT) ? MAX_BAND_COUNT : bands_reg;
            col = 0;
            row = 0;
            in_band = 0;
            if (w > MAX_ROW_PIXELS)
            begin
                bands_live = 0;
                return;
            end
            frame_cnt = frame_cnt + 1;
            bands_live = n;
            slow = frame_cnt / p;
            for (int b = 0; b < n; b++)
            begin
                s = mix(slow + 32'(b) * 32'd2654435761, 32'hCAFEBABE);
                bh = MIN_BAND_ROWS + (mix(s, 1) % (MAX_BAND_ROWS - MIN_BAND_ROWS + 1));
                y0 = mix(s, 2) % h;
                if (y0 + bh >= longint'(h)) y0 = longint'(h) - 1 - bh;
                if (y0 < 0) y0 = 0;
                top_row[b] = 32'(y0);
                bot_row[b] = 32'(y0 + bh);
                seed[b] = s;
            end
        endfunction

        function void begin_row(logic [23:0] pix);
            logic [31:0] sl;
            in_band = 0;
            for (int b = 0; b < bands_live; b++)
            begin
                if (row >= top_row[b] && row <= bot_row[b])
                begin
                    sl = (slab_reg == 0) ? 1 : slab_reg;
                    if (sl > MAX_SLAB_ROWS) sl = MAX_SLAB_ROWS;
                    in_band = 1;
                    lcg = mix(seed[b] ^ (((row / sl) * sl) << 3), 32'hFEEDF00D);
                    held = pix;
                    return;
                end
            end
        endfunction

        function void note_pixel(bit first, logic [7:0] r, logic [7:0] g, logic [7:0] bl);
            logic [23:0] pix, res;
            logic [31:0] w;
            pixel_out_t o;
            pix = {bl, g, r};
            res = pix;
            if (first) begin_frame();
            if (col == 0) begin_row(pix);
            if (in_band)
            begin
                lcg = lcg * 32'd1664525 + 32'd1013904223;
                if (lcg <= thresh_reg) res = held;
                else held = pix;
            end
            w = (width_reg == 0) ? 1 : width_reg;
            o.row_end = (col + 1 >= w);
            if (o.row_end)
            begin
                col = 0;
                if (row < 8191) row++;
            end
            else
                col++;
            o.red = res[7:0];
            o.green = res[15:8];
            o.blue = res[23:16];
            pending.push_back(o);
        endfunction

        function void check_pixel(pixel_out_t got);
            pixel_out_t exp_px;
            if (pending.size() == 0)
            begin
                $error("unexpected output word %h", got);
                errors++;
                return;
            end
            exp_px = pending.pop_front();
            if (got.red !== exp_px.red)
            begin
                $error("red_out expected %h got %h", exp_px.red, got.red);
                errors++;
            end
            if (got.green !== exp_px.green)
            begin
                $error("green_out expected %h got %h", exp_px.green, got.green);
                errors++;
            end
            if (got.blue !== exp_px.blue)
            begin
                $error("blue_out expected %h got %h", exp_px.blue, got.blue);
                errors++;
            end
            if (got.row_end !== exp_px.row_end)
            begin
                $error("row_end expected %b got %b", exp_px.row_end, got.row_end);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        frame_first;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        row_end;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    smear_scoreboard smear_sb;
    bit  quiet_mode;
    bit  hold_output;
    int  idle_cycles;

    video_band_smear i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .frame_first (frame_first),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .row_end     (row_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Output side: random stall bursts, optional long hold-off.
    initial
    begin
        int burst;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_output)
                out_stall <= 1'b1;
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (!quiet_mode && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 19) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            smear_sb.check_pixel({red_out, green_out, blue_out, row_end});
    end

    // Watchdog: cycles with nothing accepted on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** video_band_smear: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_config(cfg_reg_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        smear_sb.write_reg(idx, value);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(bit first, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if (!quiet_mode && $urandom_range(0, 11) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        frame_first <= first;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        do @(posedge clk); while (in_stall);
        smear_sb.note_pixel(first, r, g, b);
    endtask

    task automatic send_random(bit first);
        send_pixel(first, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Whole frames of random pixels; an odd stray frame-first bit now and then.
    task automatic send_frames(int frames, int w, int h);
        for (int f = 0; f < frames; f++)
            for (int i = 0; i < w * h; i++)
                send_random(i == 0 || $urandom_range(0, 299) == 0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        frame_first <= 1'b0;
        @(posedge clk);
        while (smear_sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        smear_sb = new();
        quiet_mode = 0;
        hold_output = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        frame_first = 1'b0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // before any frame start: pass-through, then extremes of the pixel fields
        send_pixel(0, 8'h00, 8'h00, 8'h00);
        send_pixel(0, 8'hff, 8'hff, 8'hff);
        send_pixel(0, 8'haa, 8'h55, 8'hff);
        drain();
        write_config(REG_FRAME_WIDTH, 4);
        write_config(REG_FRAME_HEIGHT, 6);
        write_config(REG_BAND_COUNT, 7);     // saturates
        write_config(REG_SLAB_ROWS, 31);     // saturates
        write_config(REG_SMEAR_THRESHOLD, 32'hffff_ffff);
        write_config(REG_FLUTTER_PERIOD, 0); // treated as one
        send_pixel(1, 8'h00, 8'hff, 8'h00);
        for (int i = 0; i < 15; i++) send_random(0);
        drain();
        // too wide a frame passes through; zero width and height act as one
        write_config(REG_FRAME_WIDTH, 12'hfff);
        send_pixel(1, 8'h12, 8'h34, 8'h56);
        send_random(0);
        drain();
        write_config(REG_FRAME_WIDTH, 0);
        write_config(REG_FRAME_HEIGHT, 0);
        send_pixel(1, 8'h01, 8'h02, 8'h03);
        send_random(0);
        send_random(0);
        drain();

        // long receiver hold-off so the block fills and stalls its input
        write_config(REG_FRAME_WIDTH, 8);
        write_config(REG_FRAME_HEIGHT, 8);
        write_config(REG_BAND_COUNT, 5);
        write_config(REG_SLAB_ROWS, 0);
        write_config(REG_SMEAR_THRESHOLD, 32'h8000_0000);
        write_config(REG_FLUTTER_PERIOD, 1);
        fork
            begin
                hold_output = 1;
                repeat (400) @(posedge clk);
                hold_output = 0;
            end
            send_frames(2, 8, 8);
        join
        drain();

        write_config(REG_SLAB_ROWS, 3);
        write_config(REG_SMEAR_THRESHOLD, 32'h4000_0000);
        write_config(REG_FLUTTER_PERIOD, 3);
        write_config(REG_BAND_COUNT, 2);
        send_frames(4, 6, 30);
        drain();

        write_config(REG_FRAME_WIDTH, 2048);
        write_config(REG_FRAME_HEIGHT, 4096);
        write_config(REG_BAND_COUNT, 0);
        write_config(REG_SLAB_ROWS, 16);
        write_config(REG_SMEAR_THRESHOLD, 0);
        write_config(REG_FLUTTER_PERIOD, 10000);
        send_frames(1, 2048, 1);
        drain();

        // many short rows after one frame start: row counter runs past the frame height
        write_config(REG_FRAME_WIDTH, 1);
        write_config(REG_FRAME_HEIGHT, 24);
        write_config(REG_BAND_COUNT, 1);
        write_config(REG_SMEAR_THRESHOLD, 32'hc000_0000);
        write_config(REG_FLUTTER_PERIOD, 1);
        send_frames(1, 1, 200);
        drain();

        quiet_mode = 1;
        write_config(REG_FRAME_WIDTH, 5);
        write_config(REG_FRAME_HEIGHT, 12);
        write_config(REG_BAND_COUNT, 4);
        write_config(REG_SLAB_ROWS, 2);
        write_config(REG_SMEAR_THRESHOLD, $urandom);
        write_config(REG_FLUTTER_PERIOD, 2);
        send_frames(3, 5, 12);
        drain();

        // wait for quiet outputs, then report
        repeat (60) @(posedge clk);
        if (smear_sb.errors == 0 && smear_sb.pending.size() == 0)
            $display("** video_band_smear: PASSED **");
        else
            $display("** video_band_smear: FAILED **");
        $finish;
    end
endmodule

>>> video_band_smear.f
rtl/core/vbs_pkg.sv
rtl/core/vbs_div.sv
rtl/core/vbs_queue.sv
rtl/core/vbs_front.sv
rtl/core/vbs_back.sv
rtl/core/video_band_smear.sv
tb/video_band_smear_tb.sv
